@@ hw/rtl/i2r_pkg.sv @@
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and functions for the Roman numeral unit.
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int VALUE_W          = 12;
   localparam int BCD_W            = 16;
   localparam int NUM_POS          = 4;
   localparam int POS_W            = 2;
   localparam int LEN_W            = 3;
   localparam int REP_W            = 2;
   localparam int STEPS_PER_STAGE  = 4;
   localparam int CHAR_W           = 8;

   localparam logic [CHAR_W-1:0] CHAR_I = 8'h49;
   localparam logic [CHAR_W-1:0] CHAR_V = 8'h56;
   localparam logic [CHAR_W-1:0] CHAR_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_L = 8'h4C;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_D = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;

   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
   localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd1;
   localparam logic [POS_W-1:0] POS_TENS      = 2'd2;
   localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

   typedef struct packed {
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] bin;
   } dabble_type;

   typedef struct packed {
      logic [NUM_POS-1:0][3:0]       digit;
      logic [NUM_POS-1:0][LEN_W-1:0] len;
      logic [NUM_POS-1:0]            nz;
      logic [NUM_POS-1:0]            tail;
   } digits_type;

   // one shift-add-3 step of the binary to bcd conversion
   function automatic dabble_type dabble_step(dabble_type s);
      logic [BCD_W-1:0] b;
      dabble_type       r;
      b = s.bcd;
      for (int i = 0; i < NUM_POS; i++) begin
         if (b[i*4 +: 4] >= 4'd5) begin
            b[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
         end
      end
      r = {b, s.bin} << 1;
      return r;
   endfunction

   // number of letters a decimal digit produces at a position
   function automatic logic [LEN_W-1:0] digit_len(logic [POS_W-1:0] pos, logic [3:0] d);
      logic [LEN_W-1:0] n;
      if (pos == POS_THOUSANDS) begin
         n = d[LEN_W-1:0];
      end else begin
         unique case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
         endcase
      end
      return n;
   endfunction

   // letter number k of a digit at a position
   function automatic logic [CHAR_W-1:0] digit_letter(logic [POS_W-1:0] pos, logic [3:0] d,
                                                      logic [REP_W-1:0] k);
      logic [CHAR_W-1:0] one;
      logic [CHAR_W-1:0] five;
      logic [CHAR_W-1:0] ten;
      logic [CHAR_W-1:0] c;
      unique case (pos)
         POS_THOUSANDS: begin
            one = CHAR_M; five = CHAR_M; ten = CHAR_M;
         end
         POS_HUNDREDS: begin
            one = CHAR_C; five = CHAR_D; ten = CHAR_M;
         end
         POS_TENS: begin
            one = CHAR_X; five = CHAR_L; ten = CHAR_C;
         end
         default: begin
            one = CHAR_I; five = CHAR_V; ten = CHAR_X;
         end
      endcase
      if (pos == POS_THOUSANDS) begin
         c = one;
      end else begin
         unique case (d)
            4'd4:                   c = (k == 2'd0) ? one : five;
            4'd9:                   c = (k == 2'd0) ? one : ten;
            4'd5, 4'd6, 4'd7, 4'd8: c = (k == 2'd0) ? five : one;
            default:                c = one;
         endcase
      end
      return c;
   endfunction

   // lowest position with letters
   function automatic logic [POS_W-1:0] first_pos(logic [NUM_POS-1:0] nz);
      logic [POS_W-1:0] r;
      r = '0;
      for (int q = NUM_POS - 1; q >= 0; q--) begin
         if (nz[q]) begin
            r = POS_W'(q);
         end
      end
      return r;
   endfunction

   // lowest position above p with letters
   function automatic logic [POS_W-1:0] next_pos(logic [NUM_POS-1:0] nz, logic [POS_W-1:0] p);
      logic [POS_W-1:0] r;
      r = p;
      for (int q = NUM_POS - 1; q >= 0; q--) begin
         if (nz[q] && (POS_W'(q) > p)) begin
            r = POS_W'(q);
         end
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/i2r_bcd_stage.sv @@
// ----------------------------------------------------------------------------
// i2r_bcd_stage
// Pipeline stage running four shift-add-3 steps of the bcd conversion.
// ----------------------------------------------------------------------------
module i2r_bcd_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  i2r_pkg::dabble_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output i2r_pkg::dabble_type out_data
);

   logic                valid_ff;
   logic                valid_in;
   i2r_pkg::dabble_type data_ff;
   i2r_pkg::dabble_type data_in;
   i2r_pkg::dabble_type steps;
   logic                load;

   always_comb begin
      steps = in_data;
      for (int i = 0; i < i2r_pkg::STEPS_PER_STAGE; i++) begin
         steps = i2r_pkg::dabble_step(steps);
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = steps;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/i2r_digit_stage.sv @@
// ----------------------------------------------------------------------------
// i2r_digit_stage
// Splits the bcd word into digits and works out letter counts per digit.
// ----------------------------------------------------------------------------
module i2r_digit_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  i2r_pkg::dabble_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output i2r_pkg::digits_type out_data
);

   logic                valid_ff;
   logic                valid_in;
   i2r_pkg::digits_type data_ff;
   i2r_pkg::digits_type data_in;
   i2r_pkg::digits_type dec;
   logic                load;

   always_comb begin
      dec = '0;
      for (int p = 0; p < i2r_pkg::NUM_POS; p++) begin
         dec.digit[p] = in_data.bcd[(i2r_pkg::NUM_POS - 1 - p) * 4 +: 4];
         dec.len[p]   = i2r_pkg::digit_len(i2r_pkg::POS_W'(p), dec.digit[p]);
         dec.nz[p]    = |dec.len[p];
      end
      for (int p = 0; p < i2r_pkg::NUM_POS; p++) begin
         for (int q = 0; q < i2r_pkg::NUM_POS; q++) begin
            if (q > p) begin
               dec.tail[p] = dec.tail[p] | dec.nz[q];
            end
         end
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/i2r_serializer.sv @@
// ----------------------------------------------------------------------------
// i2r_serializer
// Walks the digits of one item and sends one numeral letter per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module i2r_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  i2r_pkg::digits_type             in_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [i2r_pkg::CHAR_W-1:0]      rsp_symbol_char,
   output logic                            rsp_last_symbol
);

   logic                           busy_ff, busy_in;
   i2r_pkg::digits_type            item_ff, item_in;
   logic [i2r_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [i2r_pkg::REP_W-1:0]      k_ff, k_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [i2r_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           out_free;
   logic                           emit;
   logic                           digit_end;
   logic                           run_end;
   logic                           load;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign emit      = busy_ff && out_free;
   assign digit_end = ({1'b0, k_ff} == (item_ff.len[pos_ff] - 3'd1));
   assign run_end   = digit_end && !item_ff.tail[pos_ff];
   assign in_stall  = busy_ff && !(emit && run_end);
   assign load      = in_valid && !in_stall;

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      pos_in  = pos_ff;
      k_in    = k_ff;
      if (emit) begin
         if (digit_end) begin
            if (item_ff.tail[pos_ff]) begin
               pos_in = i2r_pkg::next_pos(item_ff.nz, pos_ff);
               k_in   = '0;
            end else begin
               busy_in = 1'b0;
            end
         end else begin
            k_in = k_ff + 2'd1;
         end
      end
      // items with no letters are dropped here
      if (load) begin
         item_in = in_data;
         busy_in = |in_data.nz;
         pos_in  = i2r_pkg::first_pos(in_data.nz);
         k_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         char_in      = i2r_pkg::digit_letter(pos_ff, item_ff.digit[pos_ff], k_ff);
         last_in      = run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_char = char_ff;
   assign rsp_last_symbol = last_ff;

endmodule

@@ hw/rtl/integer_to_roman_numeral_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_unit
// Converts a 12-bit binary integer into its Roman numeral, one ASCII letter
// per output item, most significant letter first.
//
// req channel: req_value is taken when req_valid is high and req_stall low.
// rsp channel: one item per letter; rsp_last_symbol marks the final letter.
// A value of zero produces no output items.
// A value passes the three conversion stages and the digit stage to the letter
// serializer. Throughput: one letter per cycle while rsp_stall is low; a value
// occupies the letter serializer until its numeral's letters (1 to 15, up to
// 15 for 3888) are all sent, while the three conversion stages and the digit
// stage take a new value every cycle behind it until they fill and stall.
// Reset clears all valid bits; no items are in flight afterwards.
// When the receiver stalls, the current letter holds on the rsp ports and the
// stall backs up through the pipeline stage by stage; nothing is lost.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [i2r_pkg::VALUE_W-1:0]         req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [i2r_pkg::CHAR_W-1:0]          rsp_symbol_char,
   output logic                                rsp_last_symbol
);

   localparam int NUM_BCD_STAGES = i2r_pkg::VALUE_W / i2r_pkg::STEPS_PER_STAGE;

   logic                valid_s [NUM_BCD_STAGES+1];
   logic                stall_s [NUM_BCD_STAGES+1];
   i2r_pkg::dabble_type data_s  [NUM_BCD_STAGES+1];
   logic                dig_valid;
   logic                dig_stall;
   i2r_pkg::digits_type dig_data;

   assign valid_s[0]     = req_valid;
   assign req_stall      = stall_s[0];
   assign data_s[0].bcd  = '0;
   assign data_s[0].bin  = req_value;

   for (genvar g = 0; g < NUM_BCD_STAGES; g++) begin : g_bcd
      i2r_bcd_stage u_bcd (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[g]),
         .in_stall  (stall_s[g]),
         .in_data   (data_s[g]),
         .out_valid (valid_s[g+1]),
         .out_stall (stall_s[g+1]),
         .out_data  (data_s[g+1])
      );
   end

   i2r_digit_stage u_digit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[NUM_BCD_STAGES]),
      .in_stall  (stall_s[NUM_BCD_STAGES]),
      .in_data   (data_s[NUM_BCD_STAGES]),
      .out_valid (dig_valid),
      .out_stall (dig_stall),
      .out_data  (dig_data)
   );

   i2r_serializer u_ser (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (dig_valid),
      .in_stall        (dig_stall),
      .in_data         (dig_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_last_symbol (rsp_last_symbol)
   );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Roman numeral unit: values are sent on the req channel, each
// accepted value is converted here into its expected letters, and every
// letter leaving the rsp channel is compared with the oldest expected one.
// Directed values, random values, a burst with no idling and a long receiver
// hold-off are run in turn, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic [i2r_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } letter_type;

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic [i2r_pkg::VALUE_W-1:0]  req_value       = '0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic [i2r_pkg::CHAR_W-1:0]   rsp_symbol_char;
   logic                         rsp_last_symbol;

   letter_type expected_letters[$];
   int         error_count     = 0;
   int         values_sent     = 0;
   int         letters_checked = 0;
   int         idle_cycles     = 0;
   int         hold_remaining  = 0;
   bit         quiet_mode      = 1'b0;

   integer_to_roman_numeral_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_last_symbol (rsp_last_symbol)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] got_val);
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_val, got_val);
      error_count++;
   endtask

   // letters of one decimal digit with its unit, five and ten letters
   function automatic void push_digit_letters(ref letter_type run[$], input int digit,
                                              input logic [i2r_pkg::CHAR_W-1:0] one,
                                              input logic [i2r_pkg::CHAR_W-1:0] five,
                                              input logic [i2r_pkg::CHAR_W-1:0] ten);
      letter_type l;
      int         d;
      l.last = 1'b0;
      d = digit;
      if (d == 9) begin
         l.ch = one;  run.push_back(l);
         l.ch = ten;  run.push_back(l);
      end else if (d == 4) begin
         l.ch = one;  run.push_back(l);
         l.ch = five; run.push_back(l);
      end else begin
         if (d >= 5) begin
            l.ch = five;
            run.push_back(l);
            d -= 5;
         end
         for (int k = 0; k < d; k++) begin
            l.ch = one;
            run.push_back(l);
         end
      end
   endfunction

   function automatic void predict_numeral(input logic [i2r_pkg::VALUE_W-1:0] value);
      letter_type run[$];
      letter_type l;
      int         v;
      v = int'(value);
      l.last = 1'b0;
      l.ch   = i2r_pkg::CHAR_M;
      for (int k = 0; k < v / 1000; k++) begin
         run.push_back(l);
      end
      push_digit_letters(run, (v / 100) % 10, i2r_pkg::CHAR_C, i2r_pkg::CHAR_D,
                         i2r_pkg::CHAR_M);
      push_digit_letters(run, (v / 10) % 10, i2r_pkg::CHAR_X, i2r_pkg::CHAR_L,
                         i2r_pkg::CHAR_C);
      push_digit_letters(run, v % 10, i2r_pkg::CHAR_I, i2r_pkg::CHAR_V, i2r_pkg::CHAR_X);
      if (run.size() > 0) begin
         run[run.size() - 1].last = 1'b1;
      end
      foreach (run[i]) begin
         expected_letters.push_back(run[i]);
      end
   endfunction

   // prediction at each accepted item
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_numeral(req_value);
         values_sent++;
      end
   end

   // result check
   always @(posedge clock) begin
      letter_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_letters.size() == 0) begin
            report_mismatch("unexpected letter", 32'h0, 32'(rsp_symbol_char));
         end else begin
            exp = expected_letters.pop_front();
            if (rsp_symbol_char !== exp.ch) begin
               report_mismatch("symbol_char", 32'(exp.ch), 32'(rsp_symbol_char));
            end
            if (rsp_last_symbol !== exp.last) begin
               report_mismatch("last_symbol", 32'(exp.last), 32'(rsp_last_symbol));
            end
            letters_checked++;
         end
      end
   end

   // receiver stalls: long hold-off when asked, else random
   always @(posedge clock) begin
      if (hold_remaining > 0) begin
         rsp_stall <= 1'b1;
         hold_remaining <= hold_remaining - 1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_value(input logic [i2r_pkg::VALUE_W-1:0] value);
      while (!quiet_mode && ($urandom_range(99) < 12)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [i2r_pkg::VALUE_W-1:0] digit_shaped_value();
      int v;
      v = $urandom_range(3) * 1000 + $urandom_range(9) * 100 + $urandom_range(9) * 10
          + $urandom_range(9);
      if (v == 0) begin
         v = 1;
      end
      return i2r_pkg::VALUE_W'(v);
   endfunction

   task automatic test_directed();
      int values[] = '{1, 3999, 3888, 4, 9, 5, 8, 10, 40, 90, 50, 400, 900, 500, 1000,
                       3000, 2047, 2048, 444, 999, 1994, 1111, 2444, 3949};
      foreach (values[i]) begin
         send_value(i2r_pkg::VALUE_W'(values[i]));
      end
   endtask

   task automatic test_random_values(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1) == 0) begin
            send_value(i2r_pkg::VALUE_W'($urandom_range(3999, 1)));
         end else begin
            send_value(digit_shaped_value());
         end
      end
   endtask

   task automatic test_no_idle_burst(input int count);
      quiet_mode = 1'b1;
      test_random_values(count);
      quiet_mode = 1'b0;
   endtask

   task automatic test_receiver_hold_off(input int count);
      hold_remaining = HOLD_CYCLES;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            send_value(i2r_pkg::VALUE_W'(3888));
         end else begin
            send_value(digit_shaped_value());
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_values(200);
      test_no_idle_burst(100);
      test_receiver_hold_off(40);
      test_random_values(116);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_letters.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_letters.size() != 0) begin
         report_mismatch("letters left over", 32'h0, 32'(expected_letters.size()));
      end
      $display("converted %0d values into %0d checked letters", values_sent, letters_checked);
      $display("with random gaps, a no-idle burst and a %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
